@@ hdl/swr_pkg.sv @@
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and codes for the stack with indexed removal.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam int ID_W   = 32;
    localparam int TAG_W  = 64;
    localparam int POS_W  = 8;
    localparam int FILL_W = 8;
    localparam int REQ_W  = 3;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    // move command for one storage cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } shift_cmd_t;

endpackage

@@ hdl/swr_cell.sv @@
// ----------------------------------------------------------------------------
// swr_cell
// One stack slot: holds an entry, loads from the neighbor above or below.
// ----------------------------------------------------------------------------
module swr_cell
(
    input  logic                                clk,
    input  swr_pkg::shift_cmd_t                 cmd,
    input  logic signed [swr_pkg::ID_W-1:0]     above_id,
    input  logic        [swr_pkg::TAG_W-1:0]    above_tag,
    input  logic signed [swr_pkg::ID_W-1:0]     below_id,
    input  logic        [swr_pkg::TAG_W-1:0]    below_tag,
    output logic signed [swr_pkg::ID_W-1:0]     id,
    output logic        [swr_pkg::TAG_W-1:0]    tag
);

    logic signed [swr_pkg::ID_W-1:0]  id_reg;
    logic signed [swr_pkg::ID_W-1:0]  id_next;
    logic        [swr_pkg::TAG_W-1:0] tag_reg;
    logic        [swr_pkg::TAG_W-1:0] tag_next;

    always_comb
    begin
        id_next  = id_reg;
        tag_next = tag_reg;
        if (cmd.shift_up)
        begin
            id_next  = above_id;
            tag_next = above_tag;
        end
        else if (cmd.shift_down)
        begin
            id_next  = below_id;
            tag_next = below_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        tag_reg <= tag_next;
    end

    assign id  = id_reg;
    assign tag = tag_reg;

endmodule

@@ hdl/swr_ctrl.sv @@
// ----------------------------------------------------------------------------
// swr_ctrl
// Request decode, fill count and result formation for the cell chain.
// ----------------------------------------------------------------------------
module swr_ctrl
#(
    parameter int DEPTH = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [swr_pkg::REQ_W-1:0]           req_type,
    input  logic [swr_pkg::POS_W-1:0]           position,
    input  logic signed [swr_pkg::ID_W-1:0]     top_id,
    input  logic        [swr_pkg::TAG_W-1:0]    top_tag,
    output swr_pkg::shift_cmd_t                 cmd,
    output logic [$clog2(DEPTH)-1:0]            low_idx,
    output swr_pkg::status_t                    res_status,
    output logic signed [swr_pkg::ID_W-1:0]     res_id,
    output logic        [swr_pkg::TAG_W-1:0]    res_tag,
    output logic [swr_pkg::FILL_W-1:0]          res_fill
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > swr_pkg::POS_W) ? CW : swr_pkg::POS_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CMPW-1:0]     pos_diff;
    logic                pos_ok;
    swr_pkg::shift_cmd_t cmd_dec;

    assign pos_ok   = (position != '0) && (CMPW'(position) <= CMPW'(count_reg));
    assign pos_diff = CMPW'(count_reg) - CMPW'(position);

    always_comb
    begin
        res_status = swr_pkg::STAT_OK;
        res_id     = '0;
        res_tag    = '0;
        cmd_dec    = '0;
        low_idx    = '0;
        count_next = count_reg;
        case (req_type)
            swr_pkg::REQ_PUSH:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    res_status = swr_pkg::STAT_FULL;
                end
                else
                begin
                    cmd_dec.shift_up = 1'b1;
                    count_next       = count_reg + CW'(1);
                end
            end
            swr_pkg::REQ_POP, swr_pkg::REQ_PEEK:
            begin
                if (count_reg == '0)
                begin
                    res_status = swr_pkg::STAT_EMPTY;
                end
                else
                begin
                    res_id  = top_id;
                    res_tag = top_tag;
                    if (req_type == swr_pkg::REQ_POP)
                    begin
                        cmd_dec.shift_down = 1'b1;
                        count_next         = count_reg - CW'(1);
                    end
                end
            end
            swr_pkg::REQ_REMOVE:
            begin
                // cells from the removed slot toward the bottom pull up by one
                if (pos_ok)
                begin
                    cmd_dec.shift_down = 1'b1;
                    low_idx            = IW'(pos_diff);
                    count_next         = count_reg - CW'(1);
                end
                else
                begin
                    res_status = swr_pkg::STAT_BADPOS;
                end
            end
            swr_pkg::REQ_COUNT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign cmd      = accept ? cmd_dec : '0;
    assign res_fill = swr_pkg::FILL_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/stack_with_indexed_removal.sv @@
// ----------------------------------------------------------------------------
// stack_with_indexed_removal
// Bounded LIFO of id/tag entries with pop, peek, count and removal by
// position, held in a chain of shifting cells with the top in cell zero.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | into      | in_valid / in_ready    | req_type item_id item_tag position
//  out     | out of    | out_valid / out_ready  | status out_id out_tag fill_level
//
//  one request per cycle unless out_ready stalls; its result appears in the
//  output register on the next cycle, since every cell moves at once on its own enable
//  reset clears the fill count and the output valid; cell contents are not reset
//  out_ready low holds the result and drops in_ready until it is taken
// ----------------------------------------------------------------------------
module stack_with_indexed_removal
#(
    parameter int DEPTH = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [swr_pkg::REQ_W-1:0]           req_type,
    input  logic signed [swr_pkg::ID_W-1:0]     item_id,
    input  logic        [swr_pkg::TAG_W-1:0]    item_tag,
    input  logic [swr_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [swr_pkg::ID_W-1:0]     out_id,
    output logic        [swr_pkg::TAG_W-1:0]    out_tag,
    output logic [swr_pkg::FILL_W-1:0]          fill_level
);

    localparam int IW = $clog2(DEPTH);

    logic                               accept;
    swr_pkg::shift_cmd_t                cmd;
    logic [IW-1:0]                      low_idx;
    swr_pkg::status_t                   res_status;
    logic signed [swr_pkg::ID_W-1:0]    res_id;
    logic        [swr_pkg::TAG_W-1:0]   res_tag;
    logic [swr_pkg::FILL_W-1:0]         res_fill;

    logic signed [swr_pkg::ID_W-1:0]    cell_id  [DEPTH];
    logic        [swr_pkg::TAG_W-1:0]   cell_tag [DEPTH];

    logic                               out_valid_reg;
    logic                               out_valid_next;
    swr_pkg::status_t                   status_reg;
    logic signed [swr_pkg::ID_W-1:0]    out_id_reg;
    logic        [swr_pkg::TAG_W-1:0]   out_tag_reg;
    logic [swr_pkg::FILL_W-1:0]         fill_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    swr_ctrl #(.DEPTH(DEPTH)) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .position   (position),
        .top_id     (cell_id[0]),
        .top_tag    (cell_tag[0]),
        .cmd        (cmd),
        .low_idx    (low_idx),
        .res_status (res_status),
        .res_id     (res_id),
        .res_tag    (res_tag),
        .res_fill   (res_fill)
    );

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++)
        begin : g_cell
            swr_pkg::shift_cmd_t                cell_cmd;
            logic signed [swr_pkg::ID_W-1:0]    above_id;
            logic        [swr_pkg::TAG_W-1:0]   above_tag;
            logic signed [swr_pkg::ID_W-1:0]    below_id;
            logic        [swr_pkg::TAG_W-1:0]   below_tag;

            assign cell_cmd.shift_up   = cmd.shift_up;
            assign cell_cmd.shift_down = cmd.shift_down && (low_idx <= IW'(j));

            if (j == 0)
            begin : g_top
                assign above_id  = item_id;
                assign above_tag = item_tag;
            end
            else
            begin : g_mid
                assign above_id  = cell_id[j-1];
                assign above_tag = cell_tag[j-1];
            end

            // the bottom cell has no neighbor below; what it loads is never read
            if (j == DEPTH - 1)
            begin : g_bot
                assign below_id  = cell_id[j];
                assign below_tag = cell_tag[j];
            end
            else
            begin : g_inner
                assign below_id  = cell_id[j+1];
                assign below_tag = cell_tag[j+1];
            end

            swr_cell u_cell
            (
                .clk       (clk),
                .cmd       (cell_cmd),
                .above_id  (above_id),
                .above_tag (above_tag),
                .below_id  (below_id),
                .below_tag (below_tag),
                .id        (cell_id[j]),
                .tag       (cell_tag[j])
            );
        end
    endgenerate

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= res_status;
            out_id_reg  <= res_id;
            out_tag_reg <= res_tag;
            fill_reg    <= res_fill;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_id     = out_id_reg;
    assign out_tag    = out_tag_reg;
    assign fill_level = fill_reg;

endmodule

@@ hdl/swr_checker.sv @@
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks for the stack with indexed removal.
// ----------------------------------------------------------------------------
module swr_checker
#(
    parameter int DEPTH = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [swr_pkg::REQ_W-1:0]           req_type,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [1:0]                          status,
    input  logic signed [swr_pkg::ID_W-1:0]     out_id,
    input  logic        [swr_pkg::TAG_W-1:0]    out_tag,
    input  logic [swr_pkg::FILL_W-1:0]          fill_level
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
            && $stable(out_tag) && $stable(fill_level))
    else $error("stalled result changed");

    // an accepted push answers ok or full on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == swr_pkg::REQ_PUSH |=>
            out_valid && (status == swr_pkg::STAT_OK || status == swr_pkg::STAT_FULL))
    else $error("push request gave wrong status");

    // full is only reported at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == swr_pkg::STAT_FULL |-> fill_level == swr_pkg::FILL_W'(DEPTH))
    else $error("full status below capacity");

    // empty result carries no entry and no fill
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == swr_pkg::STAT_EMPTY |->
            out_id == '0 && out_tag == '0 && fill_level == '0)
    else $error("empty result not cleared");

endmodule

bind stack_with_indexed_removal swr_checker #(.DEPTH(DEPTH)) u_swr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_id     (out_id),
    .out_tag    (out_tag),
    .fill_level (fill_level)
);

@@ dv/swr_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swr_scoreboard_pkg
// Stack predictor and result scoreboard for the indexed-removal stack bench.
// Tracks held entries bottom first and queues the expected result of every
// accepted request, then compares each returned result field by field.
// ----------------------------------------------------------------------------
package swr_scoreboard_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int MAX_REPORTS = 10;

    // spare request codes, decoded like count
    localparam logic [swr_pkg::REQ_W-1:0] REQ_RSVD_5 = 3'd5;
    localparam logic [swr_pkg::REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [swr_pkg::REQ_W-1:0] REQ_RSVD_7 = 3'd7;

    typedef struct packed {
        logic signed [swr_pkg::ID_W-1:0] id;
        logic [swr_pkg::TAG_W-1:0]       tag;
    } stack_entry_t;

    typedef struct packed {
        swr_pkg::status_t                st;
        logic signed [swr_pkg::ID_W-1:0] id;
        logic [swr_pkg::TAG_W-1:0]       tag;
        logic [swr_pkg::FILL_W-1:0]      fill;
    } stack_result_t;

    class stack_scoreboard;
        stack_entry_t  held[$];
        stack_result_t awaited[$];
        int unsigned   errors;
        int unsigned   checked;
        int unsigned   n_full;
        int unsigned   n_empty;
        int unsigned   n_badpos;
        int unsigned   peak;

        function int unsigned level();
            return held.size();
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void note_request(logic [swr_pkg::REQ_W-1:0] kind,
                                   logic signed [swr_pkg::ID_W-1:0] id,
                                   logic [swr_pkg::TAG_W-1:0] tag,
                                   logic [swr_pkg::POS_W-1:0] pos);
            stack_result_t r;
            stack_entry_t  e;
            r.st  = swr_pkg::STAT_OK;
            r.id  = '0;
            r.tag = '0;
            case (kind)
                swr_pkg::REQ_PUSH:
                    if (held.size() >= STACK_DEPTH)
                    begin
                        r.st = swr_pkg::STAT_FULL;
                        n_full++;
                    end
                    else
                    begin
                        e.id  = id;
                        e.tag = tag;
                        held.push_back(e);
                    end
                swr_pkg::REQ_POP, swr_pkg::REQ_PEEK:
                    if (held.size() == 0)
                    begin
                        r.st = swr_pkg::STAT_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        r.id  = held[$].id;
                        r.tag = held[$].tag;
                        if (kind == swr_pkg::REQ_POP)
                            void'(held.pop_back());
                    end
                swr_pkg::REQ_REMOVE:
                    // position counts from the bottom, starting at one
                    if (pos >= 1 && int'(pos) <= held.size())
                        held.delete(int'(pos) - 1);
                    else
                    begin
                        r.st = swr_pkg::STAT_BADPOS;
                        n_badpos++;
                    end
                default:
                    ;
            endcase
            r.fill = swr_pkg::FILL_W'(held.size());
            if (held.size() > peak)
                peak = held.size();
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [swr_pkg::ID_W-1:0] id,
                                   logic [swr_pkg::TAG_W-1:0] tag,
                                   logic [swr_pkg::FILL_W-1:0] fill);
            stack_result_t r;
            checked++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d id %0d tag %h fill %0d",
                             st, id, tag, fill);
                return;
            end
            r = awaited.pop_front();
            if (st !== r.st || id !== r.id || tag !== r.tag || fill !== r.fill)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("mismatch on result %0d:", checked);
                    $display("  expected status %0d id %0d tag %h fill %0d",
                             r.st, r.id, r.tag, r.fill);
                    $display("  actual   status %0d id %0d tag %h fill %0d",
                             st, id, tag, fill);
                end
            end
        endfunction
    endclass

endpackage

@@ dv/stack_with_indexed_removal_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_indexed_removal_test
// Self-checking bench for the stack with indexed removal.
// Directed corner requests, then random phases that fill the stack to
// capacity, remove at random positions and drain it, with random idle gaps
// on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module stack_with_indexed_removal_test;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [swr_pkg::REQ_W-1:0]        req_type = swr_pkg::REQ_COUNT;
    logic signed [swr_pkg::ID_W-1:0]  item_id = '0;
    logic [swr_pkg::TAG_W-1:0]        item_tag = '0;
    logic [swr_pkg::POS_W-1:0]        position = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [1:0]                       status;
    logic signed [swr_pkg::ID_W-1:0]  out_id;
    logic [swr_pkg::TAG_W-1:0]        out_tag;
    logic [swr_pkg::FILL_W-1:0]       fill_level;

    int unsigned                         cycles = 0;
    bit                                  in_calm = 1'b0;
    bit                                  out_calm = 1'b0;
    swr_scoreboard_pkg::stack_scoreboard sb = new();

    stack_with_indexed_removal #(.DEPTH(swr_scoreboard_pkg::STACK_DEPTH)) u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .item_id    (item_id),
        .item_tag   (item_tag),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_id     (out_id),
        .out_tag    (out_tag),
        .fill_level (fill_level)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [swr_pkg::REQ_W-1:0] kind,
                                input logic signed [swr_pkg::ID_W-1:0] id,
                                input logic [swr_pkg::TAG_W-1:0] tag,
                                input logic [swr_pkg::POS_W-1:0] pos);
        int unsigned gap;
        gap = in_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        item_id  <= id;
        item_tag <= tag;
        position <= pos;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_request(kind, id, tag, pos);
    endtask

    function automatic logic [swr_pkg::POS_W-1:0] pick_position();
        int unsigned lvl;
        int unsigned r;
        lvl = sb.level();
        r = $urandom_range(0, 9);
        if (r < 8 && lvl > 0)
            return swr_pkg::POS_W'($urandom_range(1, lvl));
        else if (r < 9)
            return $urandom_range(0, 1) ? '0 : swr_pkg::POS_W'(lvl + 1);
        else
            return swr_pkg::POS_W'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input int n, input int push_w, input int pop_w, input int rem_w);
        logic [swr_pkg::REQ_W-1:0] kind;
        logic [swr_pkg::POS_W-1:0] pos;
        int unsigned               r;
        repeat (n)
        begin
            if ($urandom_range(0, 39) == 0)
                in_calm = !in_calm;
            r = $urandom_range(0, 99);
            if (r < push_w)
                kind = swr_pkg::REQ_PUSH;
            else if (r < push_w + pop_w)
                kind = swr_pkg::REQ_POP;
            else if (r < push_w + pop_w + rem_w)
                kind = swr_pkg::REQ_REMOVE;
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:    kind = swr_pkg::REQ_PEEK;
                    2:       kind = swr_pkg::REQ_COUNT;
                    3:       kind = swr_scoreboard_pkg::REQ_RSVD_5;
                    4:       kind = swr_scoreboard_pkg::REQ_RSVD_6;
                    default: kind = swr_scoreboard_pkg::REQ_RSVD_7;
                endcase
            end
            if (kind == swr_pkg::REQ_REMOVE)
                pos = pick_position();
            else
                pos = swr_pkg::POS_W'($urandom_range(0, 255));
            send_request(kind, $urandom, {$urandom, $urandom}, pos);
        end
    endtask

    // result side: random stall before each result, with calm stretches
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            sb.check_result(status, out_id, out_tag, fill_level);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack corners
        send_request(swr_pkg::REQ_POP, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_PEEK, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd1);
        send_request(swr_pkg::REQ_COUNT, 32'sd0, 64'd0, 8'd0);
        // extreme payloads
        send_request(swr_pkg::REQ_PUSH, 32'sh8000_0000, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_PUSH, 32'sh7fff_ffff, {swr_pkg::TAG_W{1'b1}}, 8'hff);
        send_request(swr_pkg::REQ_PUSH, -32'sd1, 64'd99, 8'd0);
        send_request(swr_pkg::REQ_PUSH, 32'sd99, 64'h5555_aaaa_5555_aaaa, 8'd0);
        send_request(swr_pkg::REQ_PEEK, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd5);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd255);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd2);
        send_request(swr_scoreboard_pkg::REQ_RSVD_5, 32'sd0, 64'd0, 8'd0);
        send_request(swr_scoreboard_pkg::REQ_RSVD_6, 32'sd0, 64'd0, 8'd0);
        send_request(swr_scoreboard_pkg::REQ_RSVD_7, -32'sd1, {swr_pkg::TAG_W{1'b1}}, 8'hff);
        send_request(swr_pkg::REQ_PEEK, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_POP, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd3);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0, 8'd1);
        send_request(swr_pkg::REQ_POP, 32'sd0, 64'd0, 8'd0);
        send_request(swr_pkg::REQ_POP, 32'sd0, 64'd0, 8'd0);

        // fill to capacity, then hit the top edge
        random_phase(220, 85, 5, 5);
        while (sb.level() < swr_scoreboard_pkg::STACK_DEPTH)
            send_request(swr_pkg::REQ_PUSH, $urandom, {$urandom, $urandom},
                         swr_pkg::POS_W'($urandom_range(0, 255)));
        send_request(swr_pkg::REQ_PUSH, $urandom, {$urandom, $urandom}, 8'd0);
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0,
                     swr_pkg::POS_W'(swr_scoreboard_pkg::STACK_DEPTH + 1));
        send_request(swr_pkg::REQ_REMOVE, 32'sd0, 64'd0,
                     swr_pkg::POS_W'(swr_scoreboard_pkg::STACK_DEPTH));
        send_request(swr_pkg::REQ_PUSH, $urandom, {$urandom, $urandom}, 8'd0);
        send_request(swr_pkg::REQ_PUSH, $urandom, {$urandom, $urandom}, 8'd0);
        send_request(swr_pkg::REQ_PEEK, 32'sd0, 64'd0, 8'd0);

        random_phase(200, 20, 10, 55);
        random_phase(200, 10, 60, 15);
        random_phase(400, 40, 30, 15);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d results checked, %0d mismatches, peak fill %0d",
                 sb.checked, sb.errors, sb.peak);
        $display("corners hit: %0d push on full, %0d pop/peek on empty, %0d bad positions",
                 sb.n_full, sb.n_empty, sb.n_badpos);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
